// File: sv/perlin_noise_3d_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perlin noise core
// Shared concurrent checks, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_CORE_ASSERT_SVH
`define PERLIN_NOISE_3D_CORE_ASSERT_SVH

// same-cycle implication
`define PNZ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pnz assertion failed");

// next-cycle implication
`define PNZ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pnz assertion failed");

`endif

// File: sv/pnz_pkg.sv
// ----------------------------------------------------------------------------
// pnz_pkg
// Constants and permutation table for the 3D perlin noise core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pnz_pkg;

	localparam int CoordW = 32;
	localparam int CellW  = 8;
	localparam int HashW  = 4;
	localparam int NoiseW = 18;
	localparam int Depth  = 11;

	localparam logic signed [31:0] NoiseMax = 32'sd131071;
	localparam logic signed [31:0] NoiseMin = -32'sd131072;

	// gradient selection codes
	localparam logic [HashW-1:0] GradUSplit = 4'd8;
	localparam logic [HashW-1:0] GradVSplit = 4'd4;
	localparam logic [HashW-1:0] GradVx0    = 4'd12;
	localparam logic [HashW-1:0] GradVx1    = 4'd14;

	typedef logic [CellW-1:0] cell_t;
	typedef logic [HashW-1:0] hash_t;

	localparam cell_t PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
		8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
		8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
		8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
		8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
		8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
		8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
		8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
		8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
		8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
		8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
		8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
		8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
		8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
		8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
		8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
		8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
		8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
		8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
		8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

endpackage

// File: sv/pnz_fade.sv
// ----------------------------------------------------------------------------
// pnz_fade
// Five-stage quintic fade 6t^5 - 15t^4 + 10t^3, clamped to [0, 1].
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnz_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] frac,
	output logic [FRAC_BITS:0]   fade
);

	localparam int F = FRAC_BITS;
	localparam int PW = 2 * F;
	localparam logic signed [F+5:0] K6  = (F+6)'(6);
	localparam logic signed [F+5:0] K15 = (F+6)'(15);
	localparam logic signed [F+5:0] K10 = (F+6)'(10);
	localparam logic signed [F+5:0] One = (F+6)'(1) << F;

	logic [F-1:0] t_s1, t_s2, t_s3;
	logic [F-1:0] t2_s1, t3_s2, t3_s3, t3_s4, t4_s3, t4_s4, t5_s4;
	logic [F:0]   f_s5;
	logic [PW-1:0] p1, p2, p3, p4;
	logic signed [F+5:0] poly;
	logic [F:0] clamp;

	assign p1 = PW'(frac) * PW'(frac);
	assign p2 = PW'(t2_s1) * PW'(t_s1);
	assign p3 = PW'(t3_s2) * PW'(t_s2);
	assign p4 = PW'(t4_s3) * PW'(t_s3);

	always_comb begin
		poly = K6 * $signed({6'b0, t5_s4}) - K15 * $signed({6'b0, t4_s4})
			+ K10 * $signed({6'b0, t3_s4});
		if (poly < 0) begin
			clamp = '0;
		end else if (poly > One) begin
			clamp = One[F:0];
		end else begin
			clamp = poly[F:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= frac;
			t2_s1 <= p1[PW-1:F];
			t_s2  <= t_s1;
			t3_s2 <= p2[PW-1:F];
			t_s3  <= t_s2;
			t3_s3 <= t3_s2;
			t4_s3 <= p3[PW-1:F];
			t3_s4 <= t3_s3;
			t4_s4 <= t4_s3;
			t5_s4 <= p4[PW-1:F];
			f_s5  <= clamp;
		end
	end

	assign fade = f_s5;

endmodule

// File: sv/pnz_hash.sv
// ----------------------------------------------------------------------------
// pnz_hash
// Five-stage permutation hash of the cell and corner gradient dot products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnz_hash #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [pnz_pkg::CoordW-1:0]        cx,
	input  logic [pnz_pkg::CoordW-1:0]        cy,
	input  logic [pnz_pkg::CoordW-1:0]        cz,
	output logic signed [FRAC_BITS+2:0]       grad [8]
);

	localparam int F = FRAC_BITS;
	localparam logic signed [F+2:0] One = (F+3)'(1) << F;

	pnz_pkg::cell_t a_s1, b_s1, z_s1;
	pnz_pkg::cell_t aa_s2, ab_s2, ba_s2, bb_s2;
	pnz_pkg::hash_t hash_s3 [8];
	logic [F-1:0] fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;
	logic signed [F+2:0] grad_s4 [8];
	logic signed [F+2:0] grad_s5 [8];
	pnz_pkg::cell_t xc, yc, zc, xc1;

	function automatic logic signed [F+2:0] grad_dot(
		input pnz_pkg::hash_t h,
		input logic signed [F+2:0] gx,
		input logic signed [F+2:0] gy,
		input logic signed [F+2:0] gz
	);
		logic signed [F+2:0] u;
		logic signed [F+2:0] v;
		u = (h < pnz_pkg::GradUSplit) ? gx : gy;
		if (h < pnz_pkg::GradVSplit) begin
			v = gy;
		end else if (h == pnz_pkg::GradVx0 || h == pnz_pkg::GradVx1) begin
			v = gx;
		end else begin
			v = gz;
		end
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	assign xc  = cx[F +: pnz_pkg::CellW];
	assign yc  = cy[F +: pnz_pkg::CellW];
	assign zc  = cz[F +: pnz_pkg::CellW];
	assign xc1 = xc + 8'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= pnz_pkg::PERM[xc] + yc;
			b_s1  <= pnz_pkg::PERM[xc1] + yc;
			z_s1  <= zc;
			fx_s1 <= cx[F-1:0];
			fy_s1 <= cy[F-1:0];
			fz_s1 <= cz[F-1:0];

			aa_s2 <= pnz_pkg::PERM[a_s1] + z_s1;
			ab_s2 <= pnz_pkg::PERM[a_s1 + 8'd1] + z_s1;
			ba_s2 <= pnz_pkg::PERM[b_s1] + z_s1;
			bb_s2 <= pnz_pkg::PERM[b_s1 + 8'd1] + z_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;

			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
			grad_s5 <= grad_s4;
		end
	end

	// corner index {z, y, x}
	for (genvar c = 0; c < 8; c++) begin : g_corner
		pnz_pkg::cell_t base;
		logic signed [F+2:0] gx, gy, gz;
		assign base = (c % 2 == 1) ? (((c / 2) % 2 == 1) ? bb_s2 : ba_s2)
			: (((c / 2) % 2 == 1) ? ab_s2 : aa_s2);
		assign gx = (c % 2 == 1) ? $signed({3'b0, fx_s3}) - One : $signed({3'b0, fx_s3});
		assign gy = ((c / 2) % 2 == 1) ? $signed({3'b0, fy_s3}) - One
			: $signed({3'b0, fy_s3});
		assign gz = (c / 4 == 1) ? $signed({3'b0, fz_s3}) - One : $signed({3'b0, fz_s3});

		always_ff @(posedge clk) begin
			if (en) begin
				hash_s3[c] <= pnz_pkg::PERM[base + pnz_pkg::cell_t'(c / 4)][pnz_pkg::HashW-1:0];
				grad_s4[c] <= grad_dot(hash_s3[c], gx, gy, gz);
			end
		end
	end

	assign grad = grad_s5;

endmodule

// File: sv/pnz_blend.sv
// ----------------------------------------------------------------------------
// pnz_blend
// Six-stage trilinear blend of corner gradients with output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnz_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [FRAC_BITS+2:0]       grad [8],
	input  logic [FRAC_BITS:0]                fu,
	input  logic [FRAC_BITS:0]                fv,
	input  logic [FRAC_BITS:0]                fw,
	output logic [pnz_pkg::NoiseW-1:0]        noise
);

	localparam int F  = FRAC_BITS;
	localparam int GW = F + 3;
	localparam int PW = 2 * F + 6;

	logic signed [PW-1:0] xp_s6 [4];
	logic signed [GW-1:0] xa_s6 [4];
	logic signed [GW-1:0] e_s7 [4];
	logic signed [PW-1:0] yp_s8 [2];
	logic signed [GW-1:0] ya_s8 [2];
	logic signed [GW-1:0] m_s9 [2];
	logic signed [PW-1:0] zp_s10;
	logic signed [GW-1:0] za_s10;
	logic [F:0] v_s6, v_s7, w_s6, w_s7, w_s8, w_s9;
	logic [pnz_pkg::NoiseW-1:0] noise_s11;
	logic signed [GW-1:0] r;
	logic signed [31:0] r32;

	function automatic logic signed [PW-1:0] lerp_mul(
		input logic signed [GW-1:0] a,
		input logic signed [GW-1:0] b,
		input logic [F:0] w
	);
		logic signed [GW:0] d;
		d = (GW+1)'(b) - (GW+1)'(a);
		return PW'(d) * PW'($signed({1'b0, w}));
	endfunction

	function automatic logic signed [GW-1:0] lerp_add(
		input logic signed [GW-1:0] a,
		input logic signed [PW-1:0] p
	);
		logic signed [PW-1:0] sh;
		sh = p >>> F;
		return a + sh[GW-1:0];
	endfunction

	assign r   = lerp_add(za_s10, zp_s10);
	assign r32 = 32'(r);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				xp_s6[n] <= lerp_mul(grad[2*n], grad[2*n+1], fu);
				xa_s6[n] <= grad[2*n];
				e_s7[n]  <= lerp_add(xa_s6[n], xp_s6[n]);
			end
			v_s6 <= fv;
			w_s6 <= fw;
			v_s7 <= v_s6;
			w_s7 <= w_s6;
			for (int k = 0; k < 2; k++) begin
				yp_s8[k] <= lerp_mul(e_s7[2*k], e_s7[2*k+1], v_s7);
				ya_s8[k] <= e_s7[2*k];
				m_s9[k]  <= lerp_add(ya_s8[k], yp_s8[k]);
			end
			w_s8   <= w_s7;
			w_s9   <= w_s8;
			zp_s10 <= lerp_mul(m_s9[0], m_s9[1], w_s9);
			za_s10 <= m_s9[0];
			if (r32 > pnz_pkg::NoiseMax) begin
				noise_s11 <= pnz_pkg::NoiseMax[pnz_pkg::NoiseW-1:0];
			end else if (r32 < pnz_pkg::NoiseMin) begin
				noise_s11 <= pnz_pkg::NoiseMin[pnz_pkg::NoiseW-1:0];
			end else begin
				noise_s11 <= r32[pnz_pkg::NoiseW-1:0];
			end
		end
	end

	assign noise = noise_s11;

endmodule

// File: sv/perlin_noise_3d_core.sv
// Throughput: one point per cycle; the whole pipeline holds while a valid output is stalled.
// Depth is set by the fade chain (four dependent multiplies plus polynomial)
// and the three blend levels (multiply then add each).
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// perlin_noise_3d_core
// Improved 3D perlin noise, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perlin_noise_3d_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_x,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_y,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pnz_pkg::NoiseW-1:0] noise_value
);

`include "perlin_noise_3d_core_assert.svh"

	logic [pnz_pkg::Depth:1] vld_q;
	logic en;
	logic [FRAC_BITS:0] fu, fv, fw;
	logic signed [FRAC_BITS+2:0] grad [8];
	logic [pnz_pkg::NoiseW-1:0] noise;

	assign en = !(vld_q[pnz_pkg::Depth] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[pnz_pkg::Depth-1:1], in_valid};
		end
	end

	pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk(clk), .en(en), .frac(coord_x[FRAC_BITS-1:0]), .fade(fu)
	);
	pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk(clk), .en(en), .frac(coord_y[FRAC_BITS-1:0]), .fade(fv)
	);
	pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
		.clk(clk), .en(en), .frac(coord_z[FRAC_BITS-1:0]), .fade(fw)
	);

	pnz_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
		.clk(clk), .en(en),
		.cx(coord_x), .cy(coord_y), .cz(coord_z),
		.grad(grad)
	);

	pnz_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk(clk), .en(en), .grad(grad),
		.fu(fu), .fv(fv), .fw(fw),
		.noise(noise)
	);

	assign out_valid   = vld_q[pnz_pkg::Depth];
	assign noise_value = $signed(noise);

	`PNZ_ASSERT_SAME(a_stall_map, 1'b1, in_stall == (vld_q[pnz_pkg::Depth] && out_stall))
	`PNZ_ASSERT_NEXT(a_hold, !en, vld_q == $past(vld_q))
	`PNZ_ASSERT_NEXT(a_load, en, vld_q[1] == $past(in_valid))

endmodule

// File: tb/sv/perlin_noise_3d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_checker
// Watches the point and noise channels, predicts the noise value of every
// accepted point and compares it with the returned transactions in order.
// ----------------------------------------------------------------------------

module perlin_noise_3d_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_x,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_y,
	input  logic signed [pnz_pkg::CoordW-1:0] coord_z,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [pnz_pkg::NoiseW-1:0] noise_value,
	output int                                fail_count,
	output int                                pending
);
	import pnz_pkg::*;

	localparam longint One = longint'(1) << FRAC_BITS;

	logic [7:0] perm_copy [256];
	logic signed [NoiseW-1:0] noise_q[$];

	initial begin
		for (int i = 0; i < 256; i++)
			perm_copy[i] = PERM[i];
	end

	function automatic longint unsigned perm_of(longint unsigned idx);
		return longint'(perm_copy[idx[7:0]]);
	endfunction

	function automatic longint floor_frac(longint v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic longint fade_curve(longint unsigned t);
		longint unsigned t3, t4, t5;
		longint f;
		t3 = (((t * t) >> FRAC_BITS) * t) >> FRAC_BITS;
		t4 = (t3 * t) >> FRAC_BITS;
		t5 = (t4 * t) >> FRAC_BITS;
		f = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
		if (f < 0) f = 0;
		if (f > One) f = One;
		return f;
	endfunction

	function automatic longint corner_dot(longint unsigned hash, longint x, longint y,
			longint z);
		hash_t h;
		longint u, v;
		h = hash[HashW-1:0];
		u = (h < GradUSplit) ? x : y;
		v = (h < GradVSplit) ? y : ((h == GradVx0 || h == GradVx1) ? x : z);
		return ((h[0]) ? -u : u) + ((h[1]) ? -v : v);
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + floor_frac((b - a) * w);
	endfunction

	function automatic logic signed [NoiseW-1:0] noise_of(logic [31:0] cx, logic [31:0] cy,
			logic [31:0] cz);
		longint unsigned cxl, cyl, czl, a, aa, ab, b, ba, bb;
		longint x, y, z, u, v, w, xm, ym, zm, l0, l1, l3, l4, r;
		cxl = (cx >> FRAC_BITS) & 255;
		cyl = (cy >> FRAC_BITS) & 255;
		czl = (cz >> FRAC_BITS) & 255;
		x = longint'(cx) & (One - 1);
		y = longint'(cy) & (One - 1);
		z = longint'(cz) & (One - 1);
		u = fade_curve(x);
		v = fade_curve(y);
		w = fade_curve(z);
		a = perm_of(cxl) + cyl;
		aa = perm_of(a) + czl;
		ab = perm_of(a + 1) + czl;
		b = perm_of(cxl + 1) + cyl;
		ba = perm_of(b) + czl;
		bb = perm_of(b + 1) + czl;
		xm = x - One;
		ym = y - One;
		zm = z - One;
		l0 = blend(corner_dot(perm_of(ab + 1), x, ym, zm),
			corner_dot(perm_of(bb + 1), xm, ym, zm), u);
		l1 = blend(corner_dot(perm_of(aa + 1), x, y, zm),
			corner_dot(perm_of(ba + 1), xm, y, zm), u);
		l3 = blend(corner_dot(perm_of(ab), x, ym, z), corner_dot(perm_of(bb), xm, ym, z), u);
		l4 = blend(corner_dot(perm_of(aa), x, y, z), corner_dot(perm_of(ba), xm, y, z), u);
		r = blend(blend(l4, l3, v), blend(l1, l0, v), w);
		if (r > NoiseMax) r = NoiseMax;
		if (r < NoiseMin) r = NoiseMin;
		return r[NoiseW-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = noise_q.size();

	always @(posedge clk) begin
		logic signed [NoiseW-1:0] exp_noise;
		if (arst_n) begin
			if (in_valid && !in_stall)
				noise_q.push_back(noise_of(coord_x, coord_y, coord_z));
			if (out_valid && !out_stall) begin
				if (noise_q.size() == 0) begin
					report_mismatch($sformatf("unexpected noise %0d", noise_value));
				end else begin
					exp_noise = noise_q.pop_front();
					if (noise_value !== exp_noise)
						report_mismatch($sformatf("noise_value got %0d want %0d",
							noise_value, exp_noise));
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random points into the noise core under several
// idle and stall mixes; the checker predicts and compares each result.
// ----------------------------------------------------------------------------

module tb_top;
	import pnz_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CoordW-1:0] coord_x = '0;
	logic signed [CoordW-1:0] coord_y = '0;
	logic signed [CoordW-1:0] coord_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [NoiseW-1:0] noise_value;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	perlin_noise_3d_core u_top (.*);

	perlin_noise_3d_checker u_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (cycle_count > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return {{16{1'b0}}, 16'($urandom())} + ($urandom_range(3) << 16);
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: return {16'($urandom()), ($urandom_range(1) ? 16'hFFFF : 16'h0000)};
		endcase
	endfunction

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		logic [31:0] edges [6];
		edges = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_FFFF, 32'hFFFF_0000};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 6; i++)
			send_point(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
		send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		send_point(32'hFFFF_8000, 32'h00FF_4000, 32'hFF00_C000);
		for (int h = 0; h < 16; h++)
			send_point({8'd0, 8'(h), 16'h1234}, {8'd0, 8'(h * 3), 16'hABCD},
				{8'd0, 8'(255 - h), 16'h8001});
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 86; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 86; end
				3: begin idle_pct = 37; stall_pct = 37; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			for (int n = 0; n < 150; n++)
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
